>>> rtl/dshot_frame_and_telemetry_tracker_assert.svh
// Assertion macros shared by the tracker RTL.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef DSHOT_FRAME_AND_TELEMETRY_TRACKER_ASSERT_SVH
`define DSHOT_FRAME_AND_TELEMETRY_TRACKER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DFTT_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tracker assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define DFTT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tracker assertion failed");

`endif

>>> rtl/dftt_pkg.sv
`default_nettype none

package dftt_pkg;

  // The channel field is three bits wide, so at most eight channels can be addressed.
  localparam int unsigned ChannelW        = 3;
  localparam int unsigned AddrChannels    = 1 << ChannelW;
  localparam int unsigned ChannelsDefault = 8;

  localparam int unsigned ThrottleW = 11;
  localparam int unsigned PacketW   = 32;
  localparam int unsigned LineW     = 16;
  localparam int unsigned PeriodW   = 16;
  localparam int unsigned MissedW   = 8;

  localparam logic [MissedW-1:0] MaxMissedReset = 8'd10;

  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 48;

  typedef enum logic {
    CmdTransmit  = 1'b0,
    CmdTelemetry = 1'b1
  } cmd_e;

  // Result of one GCR symbol lookup: bad marks a code with no meaning.
  typedef struct packed {
    logic       bad;
    logic [3:0] nibble;
  } gcr_sym_t;

  function automatic gcr_sym_t gcr_symbol(input logic [4:0] code);
    gcr_sym_t s;
    s.bad = 1'b0;
    case (code)
      5'h09: s.nibble = 4'h9;
      5'h0A: s.nibble = 4'hA;
      5'h0B: s.nibble = 4'hB;
      5'h0D: s.nibble = 4'hD;
      5'h0E: s.nibble = 4'hE;
      5'h0F: s.nibble = 4'hF;
      5'h12: s.nibble = 4'h2;
      5'h13: s.nibble = 4'h3;
      5'h15: s.nibble = 4'h5;
      5'h16: s.nibble = 4'h6;
      5'h17: s.nibble = 4'h7;
      5'h19: s.nibble = 4'h0;
      5'h1A: s.nibble = 4'h8;
      5'h1B: s.nibble = 4'h1;
      5'h1D: s.nibble = 4'h4;
      5'h1E: s.nibble = 4'hC;
      default: begin
        s.bad    = 1'b1;
        s.nibble = 4'h0;
      end
    endcase
    return s;
  endfunction

  // Inverted XOR of the three nibbles of a 12-bit value.
  function automatic logic [3:0] nibble_crc(input logic [11:0] w);
    return ~(w[3:0] ^ w[7:4] ^ w[11:8]);
  endfunction

endpackage

`default_nettype wire

>>> rtl/dshot_frame_and_telemetry_tracker.sv
`default_nettype none

`include "dshot_frame_and_telemetry_tracker_assert.svh"

// DShot frame builder and per-channel telemetry tracker. Every transfer on the
// input stream yields exactly one transfer on the output stream. A transmit item
// (tuser = 0) returns the inverted 16-bit frame (throttle, request bit, inverted
// XOR CRC) and advances the channel's missed count, or clears its valid flag
// once the count has reached max_missed. A telemetry item (tuser = 1) GCR
// decodes the packet, whose low 21 bits carry the four transition-coded symbols
// and which must be non-zero as a whole; a good decode stores the period
// (mantissa shifted by exponent), sets valid and clears the missed count, while
// a zero packet or a bad code or CRC leaves the channel alone. Each result
// reports the channel's state after the item; a channel number at or beyond
// CHANNELS touches no state and reports zeros in the state fields. The block
// has an input register and a result register with all decoding and the
// per-channel read-modify-write combinational between them, so it takes one
// item per clock while the output is not stalled; an item moves from the input
// register into the result register once that is free, and is then offered on
// the output. The per-channel state sits in flip-flops that reset clears at
// once, so no clearing pass follows reset. max_missed is written through the
// configuration channel, which is always ready; it should only be changed while
// the block is idle.
module dshot_frame_and_telemetry_tracker #(
  parameter int unsigned CHANNELS = dftt_pkg::ChannelsDefault
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // Configuration channel: max_missed.
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [dftt_pkg::MissedW-1:0]    cfg_data_i,
  // Input stream.
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // From bit 0: channel[2:0], throttle[13:3], telem_req[14],
  // packet[46:15], zero[47].
  input  wire logic [dftt_pkg::InDataW-1:0]    s_axis_tdata,
  // cmd: 0 = transmit, 1 = telemetry packet.
  input  wire logic                            s_axis_tuser,
  // Output stream.
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // From bit 0: line_word[15:0], decode_ok[16], period[32:17],
  // telem_valid[33], miss_count[41:34], zero[47:42].
  output logic [dftt_pkg::OutDataW-1:0]        m_axis_tdata
);
  import dftt_pkg::*;

  // Only the first eight channels can ever be addressed.
  localparam int unsigned Depth = (CHANNELS < AddrChannels) ? CHANNELS : AddrChannels;
  localparam int unsigned IdxW  = (Depth > 1) ? $clog2(Depth) : 1;

  // Configuration register.
  logic [MissedW-1:0] max_missed_q;

  // Input register.
  logic                 in_valid_q;
  cmd_e                 cmd_q;
  logic [ChannelW-1:0]  chan_q;
  logic [ThrottleW-1:0] throttle_q;
  logic                 req_q;
  logic [PacketW-1:0]   packet_q;

  // Result register.
  logic                out_valid_q;
  logic [OutDataW-1:0] out_data_q;
  logic [OutDataW-1:0] out_data_d;

  // Per-channel state.
  logic [PeriodW-1:0] period_q [Depth];
  logic [Depth-1:0]   valid_q;
  logic [MissedW-1:0] missed_q [Depth];

  logic in_fire;
  logic out_free;
  logic advance;

  assign cfg_ready_o   = 1'b1;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || advance;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_missed_q <= MaxMissedReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_missed_q <= cfg_data_i;
    end
  end

  // Input register: takes a new item while empty or whenever the current one moves on.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q      <= cmd_e'(s_axis_tuser);
      chan_q     <= s_axis_tdata[2:0];
      throttle_q <= s_axis_tdata[13:3];
      req_q      <= s_axis_tdata[14];
      packet_q   <= s_axis_tdata[46:15];
    end
  end

  // Frame build for a transmit item.
  logic [11:0]      frame_data;
  logic [LineW-1:0] line_word;

  assign frame_data = {throttle_q, req_q};
  assign line_word  = ~{frame_data, nibble_crc(frame_data)};

  // Telemetry decode: undo the line's transition coding, then the 5-to-4 GCR map.
  logic [19:0]        gcr;
  gcr_sym_t           sym_crc;
  gcr_sym_t           sym_lo;
  gcr_sym_t           sym_mid;
  gcr_sym_t           sym_hi;
  logic               dec_ok;
  logic [PeriodW-1:0] dec_period;

  assign gcr     = packet_q[19:0] ^ packet_q[20:1];
  assign sym_crc = gcr_symbol(gcr[4:0]);
  assign sym_lo  = gcr_symbol(gcr[9:5]);
  assign sym_mid = gcr_symbol(gcr[14:10]);
  assign sym_hi  = gcr_symbol(gcr[19:15]);

  assign dec_ok = (packet_q != '0)
               && !sym_crc.bad && !sym_lo.bad && !sym_mid.bad && !sym_hi.bad
               && (nibble_crc({sym_hi.nibble, sym_mid.nibble, sym_lo.nibble})
                   == sym_crc.nibble);

  // Nine-bit mantissa shifted left by the three-bit exponent; never overflows.
  assign dec_period = PeriodW'({sym_hi.nibble[0], sym_mid.nibble, sym_lo.nibble})
                      << sym_hi.nibble[3:1];

  // Per-channel read-modify-write.
  logic               in_range;
  logic [IdxW-1:0]    idx;
  logic [PeriodW-1:0] cur_period;
  logic               cur_valid;
  logic [MissedW-1:0] cur_missed;
  logic [PeriodW-1:0] new_period;
  logic               new_valid;
  logic [MissedW-1:0] new_missed;
  logic               is_tx;
  logic               tel_ok;

  assign in_range   = (32'(chan_q) < 32'(CHANNELS));
  assign idx        = IdxW'(chan_q);
  assign cur_period = in_range ? period_q[idx] : '0;
  assign cur_valid  = in_range ? valid_q[idx] : 1'b0;
  assign cur_missed = in_range ? missed_q[idx] : '0;
  assign is_tx      = (cmd_q == CmdTransmit);
  assign tel_ok     = (cmd_q == CmdTelemetry) && dec_ok;

  always_comb begin
    new_period = cur_period;
    new_valid  = cur_valid;
    new_missed = cur_missed;
    if (is_tx) begin
      if (cur_missed < max_missed_q) begin
        new_missed = cur_missed + MissedW'(1);
      end else begin
        new_valid = 1'b0;
      end
    end else if (tel_ok) begin
      new_period = dec_period;
      new_valid  = 1'b1;
      new_missed = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      for (int i = 0; i < Depth; i++) begin
        period_q[i] <= '0;
        missed_q[i] <= '0;
      end
    end else if (advance && in_range) begin
      period_q[idx] <= new_period;
      valid_q[idx]  <= new_valid;
      missed_q[idx] <= new_missed;
    end
  end

  // Result register. Out-of-range channels report zeros in the state fields,
  // which the selects below force; the zeroed reads alone would not give them.
  assign out_data_d = {6'd0,
                       in_range ? new_missed : MissedW'(0),
                       in_range ? new_valid : 1'b0,
                       in_range ? new_period : PeriodW'(0),
                       tel_ok,
                       is_tx ? line_word : LineW'(0)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

  // A held input item stays put while the result register is blocked.
  `DFTT_ASSERT_NEXT(a_in_held, in_valid_q && !out_free, in_valid_q)
  // The input side only refuses a transfer while it holds an item.
  `DFTT_ASSERT_SAME(a_ready_when_empty, !s_axis_tready, in_valid_q)
  // A good decode on a real channel reports a cleared missed count and valid set.
  `DFTT_ASSERT_NEXT(a_good_decode, advance && tel_ok && in_range,
                    m_axis_tdata[41:34] == '0 && m_axis_tdata[33])
  // A transmit never reports a decode.
  `DFTT_ASSERT_NEXT(a_tx_no_decode, advance && is_tx, !m_axis_tdata[16])

endmodule

`default_nettype wire

>>> tb/dshot_frame_and_telemetry_tracker_tb.sv
`default_nettype none

// Self-checking bench for the DShot frame builder and telemetry tracker.
// A ledger object keeps its own copy of every channel's period, valid flag and
// missed count, works out the report that each accepted input transfer should
// produce, and compares the reports on the output stream against them in order.
module dshot_frame_and_telemetry_tracker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dftt_pkg::*;

  localparam int unsigned NumChannels = ChannelsDefault;
  // Settling time allowed for a result to leave after its transfer, with a little margin on top.
  localparam int unsigned SettleCycles = 4;
  // Length of the long back-pressure episode on the output stream.
  localparam int unsigned HoldCycles = 80;

  // One report as it leaves the block.
  typedef struct packed {
    logic [LineW-1:0]   line_word;
    logic               decode_ok;
    logic [PeriodW-1:0] period_val;
    logic               telem_valid;
    logic [MissedW-1:0] miss_count;
  } report_t;

  // Keeps the per-channel telemetry state and the reports still owed by the block.
  class channel_ledger;
    logic [PeriodW-1:0] period_q [AddrChannels];
    logic               valid_q  [AddrChannels];
    logic [MissedW-1:0] missed_q [AddrChannels];
    logic [MissedW-1:0] max_missed;
    int unsigned        channels;
    report_t            owed [$];
    int unsigned        errors;
    int unsigned        seen;

    function new(int unsigned n);
      channels   = n;
      max_missed = MaxMissedReset;
      errors     = 0;
      seen       = 0;
      for (int i = 0; i < AddrChannels; i++) begin
        period_q[i] = '0;
        valid_q[i]  = 1'b0;
        missed_q[i] = '0;
      end
    endfunction

    // 5-bit line code for each nibble of the GCR alphabet.
    static function logic [4:0] gcr_code(input logic [3:0] n);
      case (n)
        4'h0: return 5'h19;
        4'h1: return 5'h1B;
        4'h2: return 5'h12;
        4'h3: return 5'h13;
        4'h4: return 5'h1D;
        4'h5: return 5'h15;
        4'h6: return 5'h16;
        4'h7: return 5'h17;
        4'h8: return 5'h1A;
        4'h9: return 5'h09;
        4'hA: return 5'h0A;
        4'hB: return 5'h0B;
        4'hC: return 5'h1E;
        4'hD: return 5'h0D;
        4'hE: return 5'h0E;
        default: return 5'h0F;
      endcase
    endfunction

    // Reverse lookup; returns 0 for a code outside the alphabet.
    static function bit nibble_of(input logic [4:0] code, output logic [3:0] nib);
      nib = '0;
      for (int n = 0; n < 16; n++) begin
        if (gcr_code(4'(n)) == code) begin
          nib = 4'(n);
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function bit decode_period(input logic [31:0] pkt, output logic [PeriodW-1:0] per);
      logic [31:0] g;
      logic [3:0]  nib [0:3];
      logic [3:0]  crc_calc;
      logic [11:0] data;
      per = '0;
      if (pkt == '0) return 1'b0;
      g = pkt ^ (pkt >> 1);
      for (int k = 0; k < 4; k++) begin
        if (!nibble_of(g[k*5 +: 5], nib[k])) return 1'b0;
      end
      crc_calc = ~(nib[1] ^ nib[2] ^ nib[3]);
      if (crc_calc != nib[0]) return 1'b0;
      data = {nib[3], nib[2], nib[1]};
      per  = 16'(data[8:0]) << data[11:9];
      return 1'b1;
    endfunction

    // Called once for every input transfer the block accepts.
    function void note_item(input cmd_e cmd, input logic [2:0] ch, input logic [10:0] thr,
                            input logic req, input logic [31:0] pkt);
      report_t            r;
      logic [11:0]        w;
      logic [3:0]         crc;
      logic [PeriodW-1:0] per;
      bit                 in_range;
      int                 c;
      r        = '0;
      in_range = (ch < channels);
      c        = int'(ch);
      if (cmd == CmdTransmit) begin
        w   = {thr, req};
        crc = ~(w[3:0] ^ w[7:4] ^ w[11:8]);
        r.line_word = ~{w, crc};
        if (in_range) begin
          if (missed_q[c] < max_missed) missed_q[c] = missed_q[c] + 1'b1;
          else valid_q[c] = 1'b0;
        end
      end else if (decode_period(pkt, per)) begin
        r.decode_ok = 1'b1;
        if (in_range) begin
          period_q[c] = per;
          valid_q[c]  = 1'b1;
          missed_q[c] = '0;
        end
      end
      if (in_range) begin
        r.period_val  = period_q[c];
        r.telem_valid = valid_q[c];
        r.miss_count  = missed_q[c];
      end
      owed.push_back(r);
    endfunction

    task report_mismatch(input string msg);
      $display("ERROR: report %0d: %s", seen, msg);
      errors++;
    endtask

    // Called for every output transfer.
    task check_report(input logic [OutDataW-1:0] d);
      report_t want;
      report_t got;
      seen++;
      got.line_word   = d[15:0];
      got.decode_ok   = d[16];
      got.period_val  = d[32:17];
      got.telem_valid = d[33];
      got.miss_count  = d[41:34];
      if (owed.size() == 0) begin
        report_mismatch("report arrived with nothing outstanding");
      end else begin
        want = owed.pop_front();
        if (got.line_word !== want.line_word)
          report_mismatch($sformatf("line_word %h, want %h", got.line_word, want.line_word));
        if (got.decode_ok !== want.decode_ok)
          report_mismatch($sformatf("decode_ok %b, want %b", got.decode_ok, want.decode_ok));
        if (got.period_val !== want.period_val)
          report_mismatch($sformatf("period %0d, want %0d", got.period_val, want.period_val));
        if (got.telem_valid !== want.telem_valid)
          report_mismatch($sformatf("telem_valid %b, want %b",
                                    got.telem_valid, want.telem_valid));
        if (got.miss_count !== want.miss_count)
          report_mismatch($sformatf("miss_count %0d, want %0d",
                                    got.miss_count, want.miss_count));
      end
    endtask
  endclass

  // Clock and reset. Every input starts from a known value at time zero.
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #6 clk_i = ~clk_i;

  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic [MissedW-1:0]   cfg_data_i    = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  // From bit 0: channel[2:0], throttle[13:3], telem_req[14],
  // packet[46:15], zero[47].
  logic [InDataW-1:0]   s_axis_tdata  = '0;
  // cmd: 0 = transmit, 1 = telemetry packet.
  logic                 s_axis_tuser  = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  // From bit 0: line_word[15:0], decode_ok[16], period[32:17],
  // telem_valid[33], miss_count[41:34], zero[47:42].
  logic [OutDataW-1:0]  m_axis_tdata;

  dshot_frame_and_telemetry_tracker #(
    .CHANNELS(NumChannels)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  channel_ledger ledger;

  // Flags that shape the idling. With tx_steady the sender offers back to back;
  // with rx_steady the receiver never stalls; hold_results asks the receiver for
  // one long hold-off, which it times itself.
  bit tx_steady    = 1'b0;
  bit rx_steady    = 1'b0;
  bit hold_results = 1'b0;

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (tx_steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Builds a received word that carries the given 12-bit value. The CRC nibble can
  // be spoilt by a non-zero crc_flip. The bits above the 20 code bits are free, so
  // they come from upper; the rest follow from undoing the x ^ (x >> 1) transform
  // from the top bit down.
  function automatic logic [31:0] make_packet(input logic [11:0] data,
                                              input logic [3:0] crc_flip,
                                              input logic [11:0] upper);
    logic [19:0] g;
    logic [3:0]  crc;
    logic [31:0] p;
    crc = ~(data[3:0] ^ data[7:4] ^ data[11:8]) ^ crc_flip;
    g   = {channel_ledger::gcr_code(data[11:8]), channel_ledger::gcr_code(data[7:4]),
           channel_ledger::gcr_code(data[3:0]), channel_ledger::gcr_code(crc)};
    p   = {upper, 20'd0};
    for (int i = 19; i >= 0; i--) p[i] = g[i] ^ p[i+1];
    return p;
  endfunction

  // Offers one item after a random gap and holds it until the transfer happens.
  // When there is no gap, valid simply stays high from the previous transfer, so it
  // never receives two assignments in one time step.
  task automatic send_item(input cmd_e cmd, input logic [2:0] ch, input logic [10:0] thr,
                           input logic req, input logic [31:0] pkt);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {1'b0, pkt, req, thr, ch};
    do @(posedge clk_i); while (!s_axis_tready);
    ledger.note_item(cmd, ch, thr, req, pkt);
  endtask

  // Lowers valid once the last transfer of a phase has happened, then waits until
  // every owed report has come back.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (ledger.owed.size() != 0) @(posedge clk_i);
  endtask

  // max_missed may only change while the block is idle, so the stream is drained
  // and the pipeline given time to settle before the write transfer.
  task automatic write_max_missed(input logic [MissedW-1:0] value);
    drain();
    repeat (SettleCycles) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    ledger.max_missed = value;
  endtask

  // Random traffic: mostly transmits and well-formed telemetry, so that channels
  // climb towards the threshold and get refreshed, with a share of broken packets.
  task automatic run_random(input int unsigned count);
    int unsigned r;
    int unsigned kind;
    logic [31:0] pkt;
    for (int unsigned n = 0; n < count; n++) begin
      r   = $urandom_range(0, 99);
      pkt = make_packet(12'($urandom), 4'd0, 12'($urandom));
      if (r >= 80) begin
        kind = $urandom_range(0, 3);
        case (kind)
          0: pkt = '0;
          1: pkt = $urandom;
          2: pkt = pkt ^ (32'd1 << $urandom_range(0, 31));
          default: pkt = make_packet(12'($urandom), 4'($urandom_range(1, 15)),
                                     12'($urandom));
        endcase
      end
      send_item((r < 50) ? CmdTransmit : CmdTelemetry, 3'($urandom), 11'($urandom),
                1'($urandom), (r < 50) ? 32'($urandom) : pkt);
    end
  endtask

  // Output side: random stalls, steady stretches on request, and the long hold-off
  // during which the block fills up and has to stall its input.
  initial begin : receiver
    int unsigned r;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_results) begin
        hold_results = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else if (rx_steady) begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          m_axis_tready <= 1'b1;
          repeat ($urandom_range(1, 12)) @(posedge clk_i);
        end else begin
          m_axis_tready <= 1'b0;
          repeat ((r < 93) ? $urandom_range(1, 3) : $urandom_range(10, 35)) @(posedge clk_i);
        end
      end
    end
  end

  // Every output transfer is checked against the oldest owed report.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) ledger.check_report(m_axis_tdata);
  end

  initial begin : stimulus
    ledger = new(NumChannels);
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, with max_missed at its reset value of ten.
    // Throttle and request bit at their extremes and in alternating patterns.
    send_item(CmdTransmit, 3'd0, 11'd0, 1'b0, 32'd0);
    send_item(CmdTransmit, 3'd7, 11'h7FF, 1'b1, 32'hFFFF_FFFF);
    send_item(CmdTransmit, 3'd3, 11'h555, 1'b0, 32'h5555_5555);
    send_item(CmdTransmit, 3'd4, 11'h2AA, 1'b1, 32'hAAAA_AAAA);
    // A zero word means no packet arrived.
    send_item(CmdTelemetry, 3'd0, 11'h7FF, 1'b1, 32'd0);
    // Good decodes: zero period, the largest period, the largest mantissa
    // unshifted, and the smallest mantissa at the largest shift.
    send_item(CmdTelemetry, 3'd1, 11'd0, 1'b0, make_packet(12'h000, 4'd0, 12'h000));
    send_item(CmdTelemetry, 3'd2, 11'd0, 1'b0, make_packet(12'hFFF, 4'd0, 12'hFFF));
    send_item(CmdTelemetry, 3'd3, 11'd0, 1'b0, make_packet(12'h1FF, 4'd0, 12'h000));
    send_item(CmdTelemetry, 3'd4, 11'd0, 1'b0, make_packet(12'hE01, 4'd0, 12'h800));
    // Bad codes: all ones, bits only above the code field, and one flipped bit.
    send_item(CmdTelemetry, 3'd5, 11'd0, 1'b0, 32'hFFFF_FFFF);
    send_item(CmdTelemetry, 3'd0, 11'd0, 1'b0, 32'hFFF0_0000);
    send_item(CmdTelemetry, 3'd1, 11'd0, 1'b0, make_packet(12'h5A5, 4'd0, 12'h0) ^ 32'd1);
    // Good codes with a wrong CRC nibble.
    send_item(CmdTelemetry, 3'd6, 11'd0, 1'b0, make_packet(12'h123, 4'h1, 12'h0));
    send_item(CmdTelemetry, 3'd2, 11'd0, 1'b0, make_packet(12'hABC, 4'hF, 12'h0));
    // Run one channel past the threshold so its valid flag drops.
    for (int i = 0; i < 12; i++) send_item(CmdTransmit, 3'd2, 11'(i * 171), 1'(i), 32'd0);

    // Random phases under several thresholds, the smallest among them.
    write_max_missed(8'd0);
    run_random(20);
    write_max_missed(8'd1);
    run_random(20);
    write_max_missed(8'd3);
    run_random(20);
    write_max_missed(8'($urandom_range(2, 20)));
    run_random(20);

    // A stretch with no idling on either side.
    drain();
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    run_random(20);
    rx_steady = 1'b0;

    // Back-pressure: the receiver holds off while the sender keeps offering, so the
    // block fills and stalls its input; afterwards the sender waits for every report.
    hold_results = 1'b1;
    run_random(20);
    tx_steady = 1'b0;
    drain();

    // Largest threshold: refresh one channel, then transmit on it long enough for
    // the missed count to reach 255 and stay there while valid drops.
    write_max_missed(8'd255);
    send_item(CmdTelemetry, 3'd5, 11'd0, 1'b0, make_packet(12'($urandom), 4'd0, 12'd0));
    for (int i = 0; i < 256; i++)
      send_item(CmdTransmit, 3'd5, 11'($urandom), 1'($urandom), 32'($urandom));

    write_max_missed(MaxMissedReset);
    run_random(10);

    // Let the last reports out, then wait for anything stray before the final check.
    drain();
    repeat (SettleCycles * 2) @(posedge clk_i);
    if (ledger.owed.size() != 0)
      ledger.report_mismatch($sformatf("%0d reports never arrived", ledger.owed.size()));
    if (ledger.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin : watchdog
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
+incdir+rtl
rtl/dftt_pkg.sv
rtl/dshot_frame_and_telemetry_tracker.sv
tb/dshot_frame_and_telemetry_tracker_tb.sv
